>>> rtl/spwa_pkg.sv
// ----------------------------------------------------------------------------
// spwa_pkg
// Types and constants shared by the stub/hit window association block.
// ----------------------------------------------------------------------------
package spwa_pkg;

    localparam int MAX_PRIMARY        = 4;
    localparam int MAX_HITS_PER_LAYER = 6;
    localparam int ANGLE_BITS         = 12;

    localparam int PIDX_W = 2;
    localparam int HIDX_W = 3;
    localparam int PCNT_W = 3;
    localparam int HCNT_W = 3;

    localparam logic [1:0] KIND_PRIMARY = 2'd0;
    localparam logic [1:0] KIND_INNER   = 2'd1;
    localparam logic [1:0] KIND_OUTER   = 2'd2;

    localparam logic [2:0] ENT_MATCH_INNER = 3'd0;
    localparam logic [2:0] ENT_MATCH_OUTER = 3'd1;
    localparam logic [2:0] ENT_FREE_INNER  = 3'd2;
    localparam logic [2:0] ENT_FREE_OUTER  = 3'd3;
    localparam logic [2:0] ENT_DONE        = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADKIND  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [11:0] PHI_WINDOW_RESET = 12'd64;

    typedef struct packed {
        logic [1:0]  stub_kind;
        logic [11:0] angle;
        logic        last_in_batch;
    } t_stub_in;

    typedef struct packed {
        logic [2:0]  entry_kind;
        logic [1:0]  primary_index;
        logic [2:0]  hit_index;
        logic [11:0] angle_gap;
        logic [1:0]  status;
        logic        last_result;
    } t_entry_out;

    typedef enum logic [3:0] {
        S_LOAD,
        S_GAP,
        S_SCAN,
        S_EMIT,
        S_NEXT,
        S_FREE,
        S_DONE
    } t_state;

    // wrapped absolute angle difference, 0..half circle
    function automatic logic [ANGLE_BITS:0] wrap_gap(
        input logic [ANGLE_BITS-1:0] a,
        input logic [ANGLE_BITS-1:0] b
    );
        logic [ANGLE_BITS-1:0] d;
        logic [ANGLE_BITS:0]   r;
        d = a - b;
        if (d > ANGLE_BITS'(1 << (ANGLE_BITS - 1)))
            r = (ANGLE_BITS+1)'(1 << ANGLE_BITS) - {1'b0, d};
        else
            r = {1'b0, d};
        return r;
    endfunction

endpackage

>>> rtl/spwa_gap_unit.sv
// ----------------------------------------------------------------------------
// spwa_gap_unit
// Shared wrapped-difference and window compare, registered result.
// ----------------------------------------------------------------------------
module spwa_gap_unit (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [spwa_pkg::ANGLE_BITS-1:0] i_a,
    input  logic [spwa_pkg::ANGLE_BITS-1:0] i_b,
    input  logic [11:0]                     i_window,
    output logic [11:0]                     o_gap,
    output logic                            o_hit
);
    import spwa_pkg::*;

    logic [ANGLE_BITS:0] w_gap;

    assign w_gap = wrap_gap(i_a, i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_gap <= 12'(w_gap);
            o_hit <= (w_gap < (ANGLE_BITS+1)'(i_window));
        end
    end
endmodule

>>> rtl/stub_phi_window_association.sv
// ----------------------------------------------------------------------------
// stub_phi_window_association
// Batch association of primary stubs with inner/outer hits in azimuth.
// ----------------------------------------------------------------------------
// Stubs load one per cycle while o_in_stall is low; a stub that is not last in
// its batch yields nothing. The transaction marked last in batch starts the
// association, and input stalls until the done entry has been loaded into the
// output register. For each primary and layer, one shared difference unit
// computes the gaps one hit per cycle, then each listed match is found by a
// minimum scan of one hit per cycle and loaded into the output register in
// S_EMIT, which waits while a held entry is stalled; a final empty scan and a
// step state (S_NEXT) close the layer. The unassociated pass (S_FREE) and the
// done entry (S_DONE) follow, and each of their output steps also waits on a
// stalled output register. A batch with an error or without primaries goes
// straight to the unassociated pass, which emits nothing on error.
module stub_phi_window_association (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [11:0]           i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  spwa_pkg::t_stub_in    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output spwa_pkg::t_entry_out  o_out_data
);
    import spwa_pkg::*;

    localparam int H = MAX_HITS_PER_LAYER;

    t_state r_state, n_state;

    logic [11:0] r_window;
    logic [ANGLE_BITS-1:0] r_prim [MAX_PRIMARY];
    logic [ANGLE_BITS-1:0] r_inner [H];
    logic [ANGLE_BITS-1:0] r_outer [H];
    logic [PCNT_W-1:0] r_pcnt;
    logic [HCNT_W-1:0] r_icnt, r_ocnt;
    logic [H-1:0] r_imatch, r_omatch;
    logic [1:0] r_err;

    // work state
    logic [PIDX_W-1:0] r_p;
    logic              r_layer;       // 0 inner, 1 outer
    logic [HCNT_W-1:0] r_i;           // hit iterator
    logic              r_gap_vld;     // gap unit result pending for r_i-1
    logic [11:0]       r_gap [H];
    logic [H-1:0]      r_ok;          // in window for the current primary and layer
    logic [11:0]       r_last_gap;    // gap emitted last in this layer
    logic              r_have_last;
    logic [11:0]       r_best_gap;
    logic [HIDX_W-1:0] r_best_idx;
    logic              r_best_vld;

    logic              r_ovld;
    t_entry_out        r_odata;

    logic [HCNT_W-1:0]     w_cnt;
    logic [ANGLE_BITS-1:0] w_hit_ang;
    logic [11:0]           w_gu_gap;
    logic                  w_gu_hit;
    logic                  w_gu_en;
    logic                  w_acc;
    logic                  w_out_free;
    logic                  w_oload;
    logic [HIDX_W-1:0]     w_prev;
    logic [H-1:0]          w_flags;

    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_out_free = !r_ovld || !i_out_stall;
    assign o_in_stall = (r_state != S_LOAD);
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_odata;

    assign w_cnt     = r_layer ? r_ocnt : r_icnt;
    assign w_hit_ang = r_layer ? r_outer[r_i[HIDX_W-1:0] < HIDX_W'(H) ? r_i : '0]
                               : r_inner[r_i[HIDX_W-1:0] < HIDX_W'(H) ? r_i : '0];
    assign w_gu_en   = (r_state == S_GAP) && (r_i < w_cnt);
    assign w_prev    = r_i - 1'b1;
    assign w_flags   = r_layer ? r_omatch : r_imatch;

    // output register loads in these cycles
    assign w_oload = w_out_free && ((r_state == S_EMIT) || (r_state == S_DONE) ||
                     (r_state == S_FREE && r_i != w_cnt && r_err == ST_OK &&
                      !w_flags[r_i]));

    spwa_gap_unit u_gap (
        .i_clk    (i_clk),
        .i_en     (w_gu_en),
        .i_a      (r_prim[r_p]),
        .i_b      (w_hit_ang),
        .i_window (r_window),
        .o_gap    (w_gu_gap),
        .o_hit    (w_gu_hit)
    );

    // candidate for scan: in window, unlisted, gap above last listed gap
    logic w_cand;
    logic [11:0] w_cg;
    assign w_cg   = r_gap[r_i < HCNT_W'(H) ? r_i : '0];
    assign w_cand = (r_i < w_cnt) && r_ok[r_i < HCNT_W'(H) ? r_i : '0] &&
                    (!r_have_last || w_cg > r_last_gap);

    // error/count after the current load transaction
    function automatic logic n_err_any();
        logic e;
        e = 1'b0;
        case (i_in_data.stub_kind)
            KIND_PRIMARY: e = (r_pcnt == PCNT_W'(MAX_PRIMARY));
            KIND_INNER:   e = (r_icnt == HCNT_W'(H));
            KIND_OUTER:   e = (r_ocnt == HCNT_W'(H));
            default:      e = 1'b1;
        endcase
        return e;
    endfunction

    function automatic logic [PCNT_W-1:0] r_pcnt_n();
        logic [PCNT_W-1:0] c;
        c = r_pcnt;
        if (i_in_data.stub_kind == KIND_PRIMARY && r_pcnt != PCNT_W'(MAX_PRIMARY))
            c = r_pcnt + 1'b1;
        return c;
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_acc && i_in_data.last_in_batch) begin
                    if (r_err != ST_OK || n_err_any() || r_pcnt_n() == '0)
                        n_state = S_FREE;
                    else
                        n_state = S_GAP;
                end
            end
            S_GAP:  if (r_i == w_cnt) n_state = S_SCAN;
            S_SCAN: if (r_i == w_cnt) n_state = r_best_vld ? S_EMIT : S_NEXT;
            S_EMIT: if (w_out_free) n_state = S_SCAN;
            S_NEXT: begin
                if (r_layer && r_p == PIDX_W'(r_pcnt - 1'b1)) n_state = S_FREE;
                else n_state = S_GAP;
            end
            S_FREE: if (r_layer && r_i == r_ocnt) n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_LOAD;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)          r_ovld <= 1'b0;
        else if (w_oload)      r_ovld <= 1'b1;
        else if (!i_out_stall) r_ovld <= 1'b0;
    end

    // datapath and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= PHI_WINDOW_RESET;
            r_pcnt <= '0; r_icnt <= '0; r_ocnt <= '0;
            r_imatch <= '0; r_omatch <= '0; r_err <= ST_OK;
            r_p <= '0; r_layer <= 1'b0; r_i <= '0; r_gap_vld <= 1'b0;
            r_ok <= '0; r_have_last <= 1'b0; r_best_vld <= 1'b0;
        end else begin
            if (i_cfg_we) r_window <= i_cfg_wdata;
            unique case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        case (i_in_data.stub_kind)
                            KIND_PRIMARY: begin
                                if (r_pcnt != PCNT_W'(MAX_PRIMARY)) begin
                                    r_prim[r_pcnt[PIDX_W-1:0]] <= i_in_data.angle;
                                    r_pcnt <= r_pcnt + 1'b1;
                                end else if (r_err == ST_OK) r_err <= ST_OVERFLOW;
                            end
                            KIND_INNER: begin
                                if (r_icnt != HCNT_W'(H)) begin
                                    r_inner[r_icnt] <= i_in_data.angle;
                                    r_icnt <= r_icnt + 1'b1;
                                end else if (r_err == ST_OK) r_err <= ST_OVERFLOW;
                            end
                            KIND_OUTER: begin
                                if (r_ocnt != HCNT_W'(H)) begin
                                    r_outer[r_ocnt] <= i_in_data.angle;
                                    r_ocnt <= r_ocnt + 1'b1;
                                end else if (r_err == ST_OK) r_err <= ST_OVERFLOW;
                            end
                            default: if (r_err == ST_OK) r_err <= ST_BADKIND;
                        endcase
                        r_p <= '0; r_layer <= 1'b0; r_i <= '0;
                        r_gap_vld <= 1'b0; r_ok <= '0; r_have_last <= 1'b0;
                        r_best_vld <= 1'b0;
                    end
                end
                S_GAP: begin
                    // result of the unit lands in the cycle after issue
                    if (r_gap_vld) begin
                        r_gap[w_prev] <= w_gu_gap;
                        r_ok[w_prev]  <= w_gu_hit;
                        if (w_gu_hit) begin
                            if (r_layer) r_omatch[w_prev] <= 1'b1;
                            else         r_imatch[w_prev] <= 1'b1;
                        end
                    end
                    r_gap_vld <= w_gu_en;
                    if (w_gu_en) r_i <= r_i + 1'b1;
                    else begin
                        r_i <= '0;
                        r_have_last <= 1'b0;
                        r_best_vld <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (r_i != w_cnt) begin
                        // <= keeps the highest index on equal gaps
                        if (w_cand && (!r_best_vld || w_cg <= r_best_gap)) begin
                            r_best_vld <= 1'b1;
                            r_best_gap <= w_cg;
                            r_best_idx <= r_i;
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_odata.entry_kind    <= r_layer ? ENT_MATCH_OUTER : ENT_MATCH_INNER;
                        r_odata.primary_index <= r_p;
                        r_odata.hit_index     <= r_best_idx;
                        r_odata.angle_gap     <= r_best_gap;
                        r_odata.status        <= ST_OK;
                        r_odata.last_result   <= 1'b0;
                        r_last_gap  <= r_best_gap;
                        r_have_last <= 1'b1;
                        r_best_vld  <= 1'b0;
                        r_i <= '0;
                    end
                end
                S_NEXT: begin
                    r_i <= '0; r_ok <= '0; r_gap_vld <= 1'b0;
                    if (r_layer) begin
                        r_layer <= 1'b0;
                        if (r_p != PIDX_W'(r_pcnt - 1'b1)) r_p <= r_p + 1'b1;
                    end else r_layer <= 1'b1;
                end
                S_FREE: begin
                    if (r_i == w_cnt) begin
                        r_i <= '0;
                        r_layer <= 1'b1;
                    end else if (w_out_free) begin
                        if (r_err == ST_OK && !w_flags[r_i]) begin
                            r_odata.entry_kind    <= r_layer ? ENT_FREE_OUTER : ENT_FREE_INNER;
                            r_odata.primary_index <= '0;
                            r_odata.hit_index     <= r_i;
                            r_odata.angle_gap     <= '0;
                            r_odata.status        <= ST_OK;
                            r_odata.last_result   <= 1'b0;
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_odata.entry_kind    <= ENT_DONE;
                        r_odata.primary_index <= '0;
                        r_odata.hit_index     <= '0;
                        r_odata.angle_gap     <= '0;
                        r_odata.status        <= r_err;
                        r_odata.last_result   <= 1'b1;
                        r_pcnt <= '0; r_icnt <= '0; r_ocnt <= '0;
                        r_imatch <= '0; r_omatch <= '0; r_err <= ST_OK;
                        r_layer <= 1'b0; r_i <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // S_FREE must start on the inner layer; S_NEXT/S_LOAD leave r_layer clear.
    // With an error, S_FREE skips emission: counts may be nonzero but r_err gates.

`ifndef SYNTH
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> o_in_stall)
        else $error("input accepted while busy");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.entry_kind == ENT_DONE) |-> o_out_data.last_result)
        else $error("done entry without last flag");
    a_err_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_err != ST_OK && r_state != S_LOAD)
        |-> o_out_data.entry_kind == ENT_DONE || $past(r_ovld))
        else $error("entry emitted on error batch");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && i_out_stall) |=> r_ovld && $stable(r_odata))
        else $error("stalled result changed");
`endif
endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stub_phi_window_association: batches of stubs are
// sent with random gaps and stalls; a behavioral predictor builds the expected
// entry list per batch and a scoreboard checks every output transaction.
// ----------------------------------------------------------------------------
module tb_top;
    import spwa_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [11:0] i_cfg_wdata;
    logic       i_in_valid;
    logic       o_in_stall;
    t_stub_in   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_entry_out o_out_data;

    int idle_cycles = 0;
    bit hold_off = 0;
    bit sink_quiet = 0;

    localparam int WATCHDOG = 20000;

    stub_phi_window_association dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    class assoc_scoreboard;
        logic [11:0] window = PHI_WINDOW_RESET;
        logic [11:0] prim_ang[MAX_PRIMARY];
        logic [11:0] inner_ang[MAX_HITS_PER_LAYER];
        logic [11:0] outer_ang[MAX_HITS_PER_LAYER];
        int n_prim, n_inner, n_outer;
        bit [5:0] inner_hit, outer_hit;
        logic [1:0] err = ST_OK;
        int errors = 0;
        t_entry_out pending[$];

        function void report(string what, t_entry_out got, t_entry_out want);
            $display("MISMATCH %s: got %p want %p", what, got, want);
            errors++;
        endfunction

        function void flag(logic [1:0] code);
            if (err == ST_OK) err = code;
        endfunction

        function logic [11:0] gap_of(logic [11:0] a, logic [11:0] b);
            logic [11:0] d;
            d = a - b;
            if (d > 12'd2048) d = 12'd0 - d;
            return d;
        endfunction

        function void push(logic [2:0] k, logic [1:0] p, logic [2:0] h,
                           logic [11:0] g, logic [1:0] s, logic l);
            t_entry_out e;
            e.entry_kind = k; e.primary_index = p; e.hit_index = h;
            e.angle_gap = g; e.status = s; e.last_result = l;
            pending = {pending, e};
        endfunction

        function void match_layer(int p, bit outer);
            logic [11:0] g[MAX_HITS_PER_LAYER];
            bit ok[MAX_HITS_PER_LAYER];
            int sel[$];
            int cnt;
            bit shadow;
            cnt = outer ? n_outer : n_inner;
            for (int i = 0; i < cnt; i++) begin
                g[i] = gap_of(prim_ang[p], outer ? outer_ang[i] : inner_ang[i]);
                ok[i] = g[i] < window;
                if (ok[i]) begin
                    if (outer) outer_hit[i] = 1'b1; else inner_hit[i] = 1'b1;
                end
            end
            for (int i = 0; i < cnt; i++) begin
                int j;
                shadow = 0;
                if (!ok[i]) continue;
                for (int k = i + 1; k < cnt; k++)
                    if (ok[k] && g[k] == g[i]) shadow = 1;
                if (shadow) continue;
                // stable insertion by gap
                j = sel.size();
                while (j > 0 && g[sel[j-1]] > g[i]) j--;
                sel.insert(j, i);
            end
            foreach (sel[s])
                push(outer ? ENT_MATCH_OUTER : ENT_MATCH_INNER, p[1:0], sel[s][2:0],
                     g[sel[s]], ST_OK, 1'b0);
        endfunction

        function void note_stub(t_stub_in s);
            case (s.stub_kind)
                KIND_PRIMARY: if (n_prim < MAX_PRIMARY) prim_ang[n_prim++] = s.angle;
                              else flag(ST_OVERFLOW);
                KIND_INNER:   if (n_inner < MAX_HITS_PER_LAYER) inner_ang[n_inner++] = s.angle;
                              else flag(ST_OVERFLOW);
                KIND_OUTER:   if (n_outer < MAX_HITS_PER_LAYER) outer_ang[n_outer++] = s.angle;
                              else flag(ST_OVERFLOW);
                default:      flag(ST_BADKIND);
            endcase
            if (!s.last_in_batch) return;
            if (err == ST_OK) begin
                for (int p = 0; p < n_prim; p++) begin
                    match_layer(p, 1'b0);
                    match_layer(p, 1'b1);
                end
                for (int i = 0; i < n_inner; i++)
                    if (!inner_hit[i]) push(ENT_FREE_INNER, '0, i[2:0], '0, ST_OK, 1'b0);
                for (int i = 0; i < n_outer; i++)
                    if (!outer_hit[i]) push(ENT_FREE_OUTER, '0, i[2:0], '0, ST_OK, 1'b0);
            end
            push(ENT_DONE, '0, '0, '0, err, 1'b1);
            n_prim = 0; n_inner = 0; n_outer = 0;
            inner_hit = '0; outer_hit = '0; err = ST_OK;
        endfunction

        function void check_entry(t_entry_out got);
            t_entry_out want;
            if (pending.size() == 0) begin
                report("unexpected entry", got, got);
                return;
            end
            want = pending.pop_front();
            if (got.entry_kind != want.entry_kind) report("entry_kind", got, want);
            if (got.primary_index != want.primary_index) report("primary_index", got, want);
            if (got.hit_index != want.hit_index) report("hit_index", got, want);
            if (got.angle_gap != want.angle_gap) report("angle_gap", got, want);
            if (got.status != want.status) report("status", got, want);
            if (got.last_result != want.last_result) report("last_result", got, want);
        endfunction
    endclass

    assoc_scoreboard sb = new();

    // input monitor and output checker, sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_stub(i_in_data);
            if (o_out_valid && !i_out_stall) sb.check_entry(o_out_data);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // output side: random stalls, plus a long hold-off when asked
    initial begin
        i_out_stall = 1'b1;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off) begin
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end else if (sink_quiet || $urandom_range(0, 3) != 0) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                repeat (pick_gap() + 1) @(posedge i_clk);
            end
        end
    end

    task automatic send_stub(input logic [1:0] kind, input logic [11:0] ang, input logic last);
        int g;
        g = sink_quiet ? 0 : pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{stub_kind: kind, angle: ang, last_in_batch: last};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [11:0] w);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.window = w;
    endtask

    // batch with angles clustered so matches are likely; may add a bad kind or overflow
    task automatic random_batch();
        int np, ni, no, total;
        logic [11:0] base;
        logic [1:0] kinds[$];
        np = $urandom_range(0, MAX_PRIMARY);
        ni = $urandom_range(0, MAX_HITS_PER_LAYER);
        no = $urandom_range(0, MAX_HITS_PER_LAYER);
        repeat (np) kinds = {kinds, KIND_PRIMARY};
        repeat (ni) kinds = {kinds, KIND_INNER};
        repeat (no) kinds = {kinds, KIND_OUTER};
        if ($urandom_range(0, 9) == 0) kinds = {kinds, 2'd3};
        if ($urandom_range(0, 9) == 0) kinds = {kinds, 2'($urandom_range(0, 2))};
        kinds.shuffle();
        if (kinds.size() == 0) kinds = {kinds, KIND_PRIMARY};
        base = 12'($urandom);
        total = kinds.size();
        foreach (kinds[k]) begin
            logic [11:0] a;
            if ($urandom_range(0, 4) == 0) a = 12'($urandom);
            else a = base + 12'($urandom_range(0, 120)) - 12'd60;
            if ($urandom_range(0, 5) == 0) a = base; // equal gaps
            send_stub(kinds[k], a, k == total - 1);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset window, wrap-around, ties, batch without primaries
        send_stub(KIND_PRIMARY, 12'd0, 0);
        send_stub(KIND_INNER, 12'd4095, 0);
        send_stub(KIND_INNER, 12'd63, 0);
        send_stub(KIND_INNER, 12'd1, 0);
        send_stub(KIND_OUTER, 12'd4033, 0);
        send_stub(KIND_OUTER, 12'd2048, 1);
        send_stub(KIND_PRIMARY, 12'd100, 1);
        send_stub(KIND_INNER, 12'd5, 1);
        drain();
        write_window(12'd2048);
        send_stub(KIND_PRIMARY, 12'd2048, 0);
        send_stub(KIND_PRIMARY, 12'd4095, 0);
        send_stub(KIND_INNER, 12'd0, 0);
        send_stub(KIND_OUTER, 12'd0, 1);
        // invalid kind, then overflow
        send_stub(2'd3, 12'd7, 0);
        send_stub(KIND_INNER, 12'd7, 1);
        repeat (5) send_stub(KIND_PRIMARY, 12'd1, 0);
        send_stub(KIND_INNER, 12'd2, 1);
        drain();
        write_window(12'd0);
        send_stub(KIND_PRIMARY, 12'd10, 0);
        send_stub(KIND_INNER, 12'd10, 1);
        drain();

        // long receiver hold-off while stubs keep coming
        write_window(12'd4095);
        hold_off = 1;
        repeat (4) random_batch();
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_window(12'd64);
                1: write_window(12'($urandom_range(1, 200)));
                2: write_window(12'd2048);
                default: write_window(12'd1);
            endcase
            sink_quiet = (ph == 3);
            repeat (3) random_batch();
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
